/* design/yrgb_pkg.sv */
package yrgb_pkg;

  // Field widths fixed by the pixel stream and result format
  localparam int PIX_W      = 8;
  localparam int RGB_W      = 16;
  localparam int IDX_W      = 24;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 4;

  // Largest supported square side
  localparam int MAX_SIDE_DEF = 4096;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Frame size after reset
  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = CFG_DATA_W'(720);
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = CFG_DATA_W'(720);

  // BT.601 limited-range conversion, 8 fractional bits
  localparam int SUM_W = 20;
  localparam logic signed [SUM_W-1:0] C_Y_R   = 20'sd298;
  localparam logic signed [SUM_W-1:0] C_V_R   = 20'sd409;
  localparam logic signed [SUM_W-1:0] C_U_G   = 20'sd100;
  localparam logic signed [SUM_W-1:0] C_V_G   = 20'sd208;
  localparam logic signed [SUM_W-1:0] C_U_B   = 20'sd516;
  localparam logic signed [SUM_W-1:0] C_ROUND = 20'sd128;
  localparam logic signed [8:0]       Y_OFS   = 9'sd16;
  localparam logic signed [8:0]       C_OFS   = 9'sd128;

endpackage

/* design/yuv_to_rgb565_crop_rotate_core.sv */
// YUV to RGB565 converter with centered square crop and rotated index.
//
// Input channel (in_*): one pixel per beat in raster order, luma plus the
// chroma pair of its 2x2 block. Pixels outside the centered square of side
// S = min(width, height) are accepted and dropped without a result.
// Output channel (out_*): RGB565 pixel, destination index i*S + (S-1-j) for
// a 90-degree clockwise rotation, and a flag on the last pixel of the square.
// Config channel (cfg_*): frame_width at index 0, frame_height at index 1.
// A write to either register restarts the frame at column 0, row 0; a write
// to any other index is ignored. cfg_ready is always high.
//
// From input beat to output beat a pixel passes one input stage that
// locates the pixel in the square, then one stage with the color math and the
// i*S multiplier feeding the output register. Throughput is one pixel per
// cycle. When the receiver stalls, the output register holds and the input
// stage fills; in_ready drops only while both are full and out_ready is low.
// Reset clears the counters and pipeline valids and loads a 720x720 frame.
module yuv_to_rgb565_crop_rotate_core #(
  parameter int MAX_SIDE = yrgb_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [yrgb_pkg::PIX_W-1:0]       in_luma,
  input  logic [yrgb_pkg::PIX_W-1:0]       in_chroma_blue,
  input  logic [yrgb_pkg::PIX_W-1:0]       in_chroma_red,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [yrgb_pkg::RGB_W-1:0]       out_rgb_pixel,
  output logic [yrgb_pkg::IDX_W-1:0]       out_dest_index,
  output logic                             out_last_pixel,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [yrgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yrgb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int DW = $clog2(MAX_SIDE + 1);
  localparam int PW = CW + DW;
  localparam int SW = yrgb_pkg::SUM_W;

  typedef struct packed {
    logic [CW-1:0] w_m1;
    logic [CW-1:0] h_m1;
    logic [DW-1:0] side;
    logic [CW-1:0] side_m1;
    logic [DW-1:0] x0;
    logic [DW-1:0] x1;
    logic [DW-1:0] y0;
    logic [DW-1:0] y1;
  } geo_t;

  // Clamp a raw register value to 1..MAX_SIDE
  function automatic logic [DW-1:0] eff_dim(input logic [yrgb_pkg::CFG_DATA_W-1:0] v);
    logic [DW-1:0] d;
    if (v == '0) begin
      d = DW'(1);
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      d = DW'(MAX_SIDE);
    end else begin
      d = DW'(v);
    end
    return d;
  endfunction

  // Square side and window bounds for a frame size
  function automatic geo_t calc_geo(input logic [yrgb_pkg::CFG_DATA_W-1:0] wr,
                                    input logic [yrgb_pkg::CFG_DATA_W-1:0] hr);
    geo_t g;
    logic [DW-1:0] w;
    logic [DW-1:0] h;
    logic [DW-1:0] s;
    w = eff_dim(wr);
    h = eff_dim(hr);
    s = (w < h) ? w : h;
    g.w_m1    = CW'(w - DW'(1));
    g.h_m1    = CW'(h - DW'(1));
    g.side    = s;
    g.side_m1 = CW'(s - DW'(1));
    g.x0      = (w - s) >> 1;
    g.y0      = (h - s) >> 1;
    g.x1      = g.x0 + s;
    g.y1      = g.y0 + s;
    return g;
  endfunction

  // Scale by 1/256 with floor, then clamp to 0..255
  function automatic logic [7:0] scale_clamp(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] t;
    logic [7:0] c;
    t = x >>> 8;
    if (t < 0) begin
      c = 8'd0;
    end else if (t > 255) begin
      c = 8'd255;
    end else begin
      c = t[7:0];
    end
    return c;
  endfunction

  // Configuration registers and derived geometry
  logic [yrgb_pkg::CFG_DATA_W-1:0] fw_r, fh_r, fw_nxt, fh_nxt;
  geo_t geo_r;
  logic cfg_we, cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_we && (cfg_index == yrgb_pkg::REG_FRAME_WIDTH ||
                                cfg_index == yrgb_pkg::REG_FRAME_HEIGHT);

  always_comb begin
    fw_nxt = fw_r;
    fh_nxt = fh_r;
    if (cfg_we && cfg_index == yrgb_pkg::REG_FRAME_WIDTH) begin
      fw_nxt = cfg_data;
    end
    if (cfg_we && cfg_index == yrgb_pkg::REG_FRAME_HEIGHT) begin
      fh_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= yrgb_pkg::FRAME_WIDTH_RST;
      fh_r  <= yrgb_pkg::FRAME_HEIGHT_RST;
      geo_r <= calc_geo(yrgb_pkg::FRAME_WIDTH_RST, yrgb_pkg::FRAME_HEIGHT_RST);
    end else if (cfg_hit) begin
      fw_r  <= fw_nxt;
      fh_r  <= fh_nxt;
      geo_r <= calc_geo(fw_nxt, fh_nxt);
    end
  end

  // Pipeline handshake
  logic s1_v_r, out_v_r;
  logic s2_adv, s1_adv, in_acc;

  assign s2_adv    = !out_v_r || out_ready;
  assign s1_adv    = !s1_v_r || s2_adv;
  assign in_ready  = s1_adv;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_v_r;

  // Position counters
  logic [CW-1:0] col_r, row_r, col_nxt, row_nxt;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_r == geo_r.w_m1) begin
        col_nxt = '0;
        row_nxt = (row_r == geo_r.h_m1) ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Locate the pixel in the square
  logic keep;
  logic [CW-1:0] sq_i, sq_j;

  assign keep = (DW'(col_r) >= geo_r.x0) && (DW'(col_r) < geo_r.x1) &&
                (DW'(row_r) >= geo_r.y0) && (DW'(row_r) < geo_r.y1);
  assign sq_i = CW'(DW'(col_r) - geo_r.x0);
  assign sq_j = CW'(DW'(row_r) - geo_r.y0);

  // Input stage
  logic [yrgb_pkg::PIX_W-1:0] s1_luma_r, s1_cb_r, s1_cr_r;
  logic [CW-1:0] s1_i_r, s1_j_r, s1_side_m1_r;
  logic [DW-1:0] s1_side_r;
  logic          s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_acc && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_luma_r    <= in_luma;
      s1_cb_r      <= in_chroma_blue;
      s1_cr_r      <= in_chroma_red;
      s1_i_r       <= sq_i;
      s1_j_r       <= sq_j;
      s1_side_r    <= geo_r.side;
      s1_side_m1_r <= geo_r.side_m1;
      s1_last_r    <= (sq_i == geo_r.side_m1) && (sq_j == geo_r.side_m1);
    end
  end

  // Color conversion
  logic signed [8:0]    y9, u9, v9;
  logic signed [SW-1:0] yw, uw, vw, r_sum, g_sum, b_sum;
  logic [7:0]           r8, g8, b8;

  assign y9 = $signed({1'b0, s1_luma_r}) - yrgb_pkg::Y_OFS;
  assign u9 = $signed({1'b0, s1_cb_r}) - yrgb_pkg::C_OFS;
  assign v9 = $signed({1'b0, s1_cr_r}) - yrgb_pkg::C_OFS;
  assign yw = SW'(y9);
  assign uw = SW'(u9);
  assign vw = SW'(v9);

  assign r_sum = yrgb_pkg::C_Y_R * yw + yrgb_pkg::C_V_R * vw + yrgb_pkg::C_ROUND;
  assign g_sum = yrgb_pkg::C_Y_R * yw - yrgb_pkg::C_U_G * uw - yrgb_pkg::C_V_G * vw
               + yrgb_pkg::C_ROUND;
  assign b_sum = yrgb_pkg::C_Y_R * yw + yrgb_pkg::C_U_B * uw + yrgb_pkg::C_ROUND;

  assign r8 = scale_clamp(r_sum);
  assign g8 = scale_clamp(g_sum);
  assign b8 = scale_clamp(b_sum);

  // Rotated destination index
  logic [PW-1:0] prod;
  logic [CW-1:0] mirror_j;
  logic [PW:0]   idx_sum;

  assign prod     = PW'(s1_i_r) * PW'(s1_side_r);
  assign mirror_j = s1_side_m1_r - s1_j_r;
  assign idx_sum  = (PW + 1)'(prod) + (PW + 1)'(mirror_j);

  // Output register
  logic [yrgb_pkg::RGB_W-1:0] rgb_r;
  logic [yrgb_pkg::IDX_W-1:0] idx_r;
  logic                       last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      rgb_r  <= {r8[7:3], g8[7:2], b8[7:3]};
      idx_r  <= yrgb_pkg::IDX_W'(idx_sum);
      last_r <= s1_last_r;
    end
  end

  assign out_rgb_pixel  = rgb_r;
  assign out_dest_index = idx_r;
  assign out_last_pixel = last_r;

endmodule

/* design/yrgb_checker.sv */
module yrgb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [yrgb_pkg::PIX_W-1:0]       in_luma,
  input logic [yrgb_pkg::PIX_W-1:0]       in_chroma_blue,
  input logic [yrgb_pkg::PIX_W-1:0]       in_chroma_red,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [yrgb_pkg::RGB_W-1:0]       out_rgb_pixel,
  input logic [yrgb_pkg::IDX_W-1:0]       out_dest_index,
  input logic                             out_last_pixel,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [yrgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [yrgb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rgb_pixel) &&
      $stable(out_dest_index) && $stable(out_last_pixel))
    else $error("result beat changed while stalled");

  // Drop the result channel during reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result follows an accepted input beat through the input stage and the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching input beat");

  // Backpressure on the input only while the output stalls
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output is free");

endmodule

bind yuv_to_rgb565_crop_rotate_core yrgb_checker u_yrgb_checker (.*);

/* bench/tb_yuv_to_rgb565_crop_rotate_core.sv */
module tb_yuv_to_rgb565_crop_rotate_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes with no register behind them
  localparam logic [yrgb_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = yrgb_pkg::CFG_IDX_W'(2);
  localparam logic [yrgb_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = yrgb_pkg::CFG_IDX_W'(15);

  localparam int PIPE_FLUSH  = 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam int RAND_BEATS  = 900;
  localparam int BIG_BEATS   = 150;
  localparam int TALL_ROWS   = 201;
  localparam int DIR_ROWS    = 31;

  typedef struct packed {
    logic [yrgb_pkg::RGB_W-1:0] rgb;
    logic [yrgb_pkg::IDX_W-1:0] dest;
    logic                       last;
  } px_result_t;

  typedef enum logic [1:0] {ROW_PIX, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [yrgb_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic [yrgb_pkg::CFG_DATA_W-1:0]  reg_val;
    logic [yrgb_pkg::PIX_W-1:0]       luma;
    logic [yrgb_pkg::PIX_W-1:0]       cb;
    logic [yrgb_pkg::PIX_W-1:0]       cr;
    logic                             typed;
    logic [yrgb_pkg::RGB_W-1:0]       rgb;
    logic [yrgb_pkg::IDX_W-1:0]       dest;
    logic                             last;
  } dir_row_t;

  logic                             clk            = 1'b0;
  logic                             rst_n          = 1'b0;
  logic                             in_valid       = 1'b0;
  logic                             in_ready;
  logic [yrgb_pkg::PIX_W-1:0]       in_luma        = '0;
  logic [yrgb_pkg::PIX_W-1:0]       in_chroma_blue = '0;
  logic [yrgb_pkg::PIX_W-1:0]       in_chroma_red  = '0;
  logic                             out_valid;
  logic                             out_ready      = 1'b0;
  logic [yrgb_pkg::RGB_W-1:0]       out_rgb_pixel;
  logic [yrgb_pkg::IDX_W-1:0]       out_dest_index;
  logic                             out_last_pixel;
  logic                             cfg_valid      = 1'b0;
  logic                             cfg_ready;
  logic [yrgb_pkg::CFG_IDX_W-1:0]   cfg_index      = yrgb_pkg::REG_FRAME_WIDTH;
  logic [yrgb_pkg::CFG_DATA_W-1:0]  cfg_data       = '0;

  // Shadow of the frame registers and the raster position
  logic [yrgb_pkg::CFG_DATA_W-1:0]  frame_w_reg = yrgb_pkg::FRAME_WIDTH_RST;
  logic [yrgb_pkg::CFG_DATA_W-1:0]  frame_h_reg = yrgb_pkg::FRAME_HEIGHT_RST;
  int unsigned                      col_pos     = 0;
  int unsigned                      row_pos     = 0;

  px_result_t             pending_px[$];
  bit                     calm        = 1'b0;
  int                     err_count   = 0;
  int                     px_beats    = 0;
  int                     px_checked  = 0;
  int                     reg_writes  = 0;

  // Directed rows; typed expectations only where trivially known
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_PIX, '0, '0, 8'd16,  8'd128, 8'd128, 1'b1, 16'h0000, 24'd719,  1'b0},
    '{ROW_PIX, '0, '0, 8'd255, 8'd128, 8'd128, 1'b1, 16'hFFFF, 24'd1439, 1'b0},
    '{ROW_PIX, '0, '0, 8'd0,   8'd0,   8'd0,   1'b1, 16'h0420, 24'd2159, 1'b0},
    '{ROW_PIX, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd0,   8'd255, 8'd0,   1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd255, 8'd0,   8'd255, 1'b0, '0, '0, 1'b0},
    '{ROW_CFG, yrgb_pkg::REG_FRAME_WIDTH,  13'd0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
    '{ROW_CFG, yrgb_pkg::REG_FRAME_HEIGHT, 13'd0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd16,  8'd128, 8'd128, 1'b1, 16'h0000, 24'd0, 1'b1},
    '{ROW_PIX, '0, '0, 8'd255, 8'd128, 8'd128, 1'b1, 16'hFFFF, 24'd0, 1'b1},
    '{ROW_CFG, yrgb_pkg::REG_FRAME_WIDTH,  13'd5, '0, '0, '0, 1'b0, '0, '0, 1'b0},
    '{ROW_CFG, yrgb_pkg::REG_FRAME_HEIGHT, 13'd3, '0, '0, '0, 1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd40,  8'd60,  8'd200, 1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd100, 8'd90,  8'd30,  1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd235, 8'd240, 8'd16,  1'b0, '0, '0, 1'b0},
    '{ROW_CFG, REG_UNMAPPED_LO,  13'd7, '0, '0, '0, 1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd128, 8'd200, 8'd60,  1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd81,  8'd90,  8'd240, 1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd145, 8'd54,  8'd34,  1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd210, 8'd16,  8'd146, 1'b0, '0, '0, 1'b0},
    '{ROW_CFG, yrgb_pkg::REG_FRAME_WIDTH,  13'd3, '0, '0, '0, 1'b0, '0, '0, 1'b0},
    '{ROW_CFG, yrgb_pkg::REG_FRAME_HEIGHT, 13'd6, '0, '0, '0, 1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd60,  8'd110, 8'd170, 1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd170, 8'd170, 8'd170, 1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd30,  8'd250, 8'd5,   1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd90,  8'd100, 8'd110, 1'b0, '0, '0, 1'b0},
    '{ROW_CFG, yrgb_pkg::REG_FRAME_WIDTH,  13'h1FFF, '0, '0, '0, 1'b0, '0, '0, 1'b0},
    '{ROW_CFG, yrgb_pkg::REG_FRAME_HEIGHT, 13'h1FFF, '0, '0, '0, 1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd255, 8'd128, 8'd128, 1'b1, 16'hFFFF, 24'd4095, 1'b0},
    '{ROW_CFG, REG_UNMAPPED_HI,  13'h1FFF, '0, '0, '0, 1'b0, '0, '0, 1'b0},
    '{ROW_PIX, '0, '0, 8'd16,  8'd128, 8'd128, 1'b1, 16'h0000, 24'd8191, 1'b0}
  };

  yuv_to_rgb565_crop_rotate_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_luma        (in_luma),
    .in_chroma_blue (in_chroma_blue),
    .in_chroma_red  (in_chroma_red),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rgb_pixel  (out_rgb_pixel),
    .out_dest_index (out_dest_index),
    .out_last_pixel (out_last_pixel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Map a register value to the frame size actually used
  function automatic int unsigned clip_side(input logic [yrgb_pkg::CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > yrgb_pkg::MAX_SIDE_DEF) return yrgb_pkg::MAX_SIDE_DEF;
    return 32'(v);
  endfunction

  // Floor-divide by 256, then saturate to a byte
  function automatic logic [7:0] sat_byte(input int acc);
    int q;
    q = acc >>> 8;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // Convert one pixel if it lies in the square, then advance the raster position
  function automatic bit place_pixel(input logic [yrgb_pkg::PIX_W-1:0] l, cb, cr,
                                     output px_result_t res);
    int unsigned w, h, s, x0, y0, i, j;
    int          yy, uu, vv;
    logic [7:0]  r, g, b;
    bit          kept;
    w  = clip_side(frame_w_reg);
    h  = clip_side(frame_h_reg);
    s  = (w < h) ? w : h;
    x0 = (w - s) / 2;
    y0 = (h - s) / 2;
    kept = col_pos >= x0 && col_pos < x0 + s && row_pos >= y0 && row_pos < y0 + s;
    res = '0;
    if (kept) begin
      i  = col_pos - x0;
      j  = row_pos - y0;
      yy = int'(l) - 16;
      uu = int'(cb) - 128;
      vv = int'(cr) - 128;
      r  = sat_byte(298 * yy + 409 * vv + 128);
      g  = sat_byte(298 * yy - 100 * uu - 208 * vv + 128);
      b  = sat_byte(298 * yy + 516 * uu + 128);
      res.rgb  = {r[7:3], g[7:2], b[7:3]};
      res.dest = yrgb_pkg::IDX_W'(i * s + (s - 1 - j));
      res.last = (i == s - 1) && (j == s - 1);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return kept;
  endfunction

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 36);
  endfunction

  function automatic logic [yrgb_pkg::PIX_W-1:0] pick_sample();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(5))
        0:       return 8'd0;
        1:       return 8'd255;
        2:       return 8'd16;
        3:       return 8'd235;
        4:       return 8'd128;
        default: return 8'd240;
      endcase
    end
    return yrgb_pkg::PIX_W'($urandom_range(255));
  endfunction

  function automatic void check_field(input string name,
                                      input logic [yrgb_pkg::IDX_W-1:0] want,
                                      input logic [yrgb_pkg::IDX_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Send one pixel beat; record its conversion once accepted
  task automatic send_pixel(input logic [yrgb_pkg::PIX_W-1:0] l, cb, cr,
                            input bit use_typed, input px_result_t typed_res);
    px_result_t res;
    bit         kept;
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_luma        <= l;
    in_chroma_blue <= cb;
    in_chroma_red  <= cr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    kept = place_pixel(l, cb, cr, res);
    if (kept) pending_px.push_back(use_typed ? typed_res : res);
    px_beats++;
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(pick_sample(), pick_sample(), pick_sample(), 1'b0, '0);
  endtask

  // Drop valid, let every converted pixel come out, then flush dropped ones
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
  endtask

  task automatic write_reg(input logic [yrgb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [yrgb_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    // Mapped writes restart the frame; others leave the position alone
    if (idx == yrgb_pkg::REG_FRAME_WIDTH) begin
      frame_w_reg = val;
      col_pos = 0;
      row_pos = 0;
    end else if (idx == yrgb_pkg::REG_FRAME_HEIGHT) begin
      frame_h_reg = val;
      col_pos = 0;
      row_pos = 0;
    end
    reg_writes++;
  endtask

  // Stall the result channel at random, except in the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 36);
  end

  // Compare each result beat with the oldest pending conversion
  always @(posedge clk) begin
    px_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_px.size() == 0) begin
        $display("%0t: result beat with nothing pending: rgb 0x%0h dest 0x%0h last %b",
                 $time, out_rgb_pixel, out_dest_index, out_last_pixel);
        err_count++;
      end else begin
        want = pending_px.pop_front();
        check_field("rgb_pixel",  yrgb_pkg::IDX_W'(want.rgb),
                    yrgb_pkg::IDX_W'(out_rgb_pixel));
        check_field("dest_index", want.dest, out_dest_index);
        check_field("last_pixel", yrgb_pkg::IDX_W'(want.last),
                    yrgb_pkg::IDX_W'(out_last_pixel));
        px_checked++;
      end
    end
  end

  initial begin
    px_result_t typed_res;
    int         rand_beats;
    int         area;
    int         count;
    int         waited;
    rand_beats = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_val);
      end else begin
        typed_res.rgb  = dir_tab[k].rgb;
        typed_res.dest = dir_tab[k].dest;
        typed_res.last = dir_tab[k].last;
        send_pixel(dir_tab[k].luma, dir_tab[k].cb, dir_tab[k].cr, dir_tab[k].typed,
                   typed_res);
      end
    end

    // Clamped 4096 square: the top row steps the index by a full side
    write_reg(yrgb_pkg::REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(yrgb_pkg::REG_FRAME_HEIGHT, 13'd4097);
    send_random_pixels(BIG_BEATS);

    // One column, tall frame: only the middle row is kept
    write_reg(yrgb_pkg::REG_FRAME_WIDTH, 13'd1);
    write_reg(yrgb_pkg::REG_FRAME_HEIGHT, yrgb_pkg::CFG_DATA_W'(TALL_ROWS));
    send_random_pixels(TALL_ROWS);

    // Random small frames, partial and repeated, with occasional odd writes
    write_reg(yrgb_pkg::REG_FRAME_WIDTH, yrgb_pkg::CFG_DATA_W'($urandom_range(1, 12)));
    write_reg(yrgb_pkg::REG_FRAME_HEIGHT, yrgb_pkg::CFG_DATA_W'($urandom_range(1, 12)));
    while (rand_beats < RAND_BEATS) begin
      case ($urandom_range(9))
        0: begin
          write_reg(yrgb_pkg::REG_FRAME_WIDTH, yrgb_pkg::CFG_DATA_W'($urandom_range(13)));
          write_reg(yrgb_pkg::REG_FRAME_HEIGHT, yrgb_pkg::CFG_DATA_W'($urandom_range(13)));
        end
        1: write_reg(yrgb_pkg::REG_FRAME_WIDTH,
                     yrgb_pkg::CFG_DATA_W'($urandom_range(1, 12)));
        2: write_reg(yrgb_pkg::REG_FRAME_HEIGHT,
                     yrgb_pkg::CFG_DATA_W'($urandom_range(1, 12)));
        3: write_reg(yrgb_pkg::CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                     yrgb_pkg::CFG_DATA_W'($urandom_range(8191)));
        default: begin
          write_reg(yrgb_pkg::REG_FRAME_WIDTH,
                    yrgb_pkg::CFG_DATA_W'($urandom_range(1, 12)));
          write_reg(yrgb_pkg::REG_FRAME_HEIGHT,
                    yrgb_pkg::CFG_DATA_W'($urandom_range(1, 12)));
        end
      endcase
      calm  = rand_beats >= 450 && rand_beats < 750;
      area  = clip_side(frame_w_reg) * clip_side(frame_h_reg);
      count = area * $urandom_range(1, 2) + $urandom_range(0, area);
      if (count > 400) count = 400;
      send_random_pixels(count);
      rand_beats += count;
    end
    calm = 1'b0;

    // Drain what is still in flight
    in_valid <= 1'b0;
    waited = 0;
    while (pending_px.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_FLUSH) @(posedge clk);
    if (pending_px.size() != 0) begin
      $display("%0t: %0d converted pixels never came out", $time, pending_px.size());
      err_count++;
    end

    $display("Sent %0d pixel beats and %0d register writes, checked %0d converted pixels",
             px_beats, reg_writes, px_checked);
    $display("Frames from 1x1 to clamped 4096 wide and tall, unmapped writes, random stalls");
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop if the stream hangs
  initial begin
    #5_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
design/yrgb_pkg.sv
design/yuv_to_rgb565_crop_rotate_core.sv
design/yrgb_checker.sv
bench/tb_yuv_to_rgb565_crop_rotate_core.sv
